// File: rtl/core/pscc_pkg.sv
// ----------------------------------------------------------------------------
// pscc_pkg
// Shared types and constants of the periodic slot conflict checker: map row
// layout, epoch tag width, sequencer states and row unit structs.
// ----------------------------------------------------------------------------
package pscc_pkg;

	// field widths
	localparam int TIME_W   = 20;
	// cursor width: covers map sizes up to 2^21 cells plus one period step
	localparam int CUR_W    = 22;

	// map row layout: 64 cells per memory row
	localparam int ROW_BITS = 64;
	localparam int BIT_W    = 6;

	// epoch tag kept with every row; a stale tag reads as an empty row
	localparam int EPOCH_W  = 8;

	localparam int MAP_CELLS_DEF = 1048576;
	localparam logic [TIME_W-1:0] HORIZON_RESET = 20'd1000000;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_OCC,
		ST_READ,
		ST_CHECK,
		ST_FIN
	} state_t;

	// cell range within one row
	typedef struct packed {
		logic [BIT_W-1:0] lo_bit;
		logic [BIT_W-1:0] hi_bit;
	} row_req_t;

	// overlap verdict and updated row contents
	typedef struct packed {
		logic                hit;
		logic [ROW_BITS-1:0] data;
	} row_res_t;

endpackage

// File: rtl/core/pscc_ram.sv
// ----------------------------------------------------------------------------
// pscc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pscc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/pscc_row_unit.sv
// ----------------------------------------------------------------------------
// pscc_row_unit
// Row unit: builds the cell mask of one row segment, checks it against
// the stored row (stale epoch reads as empty) and forms the merged row.
// ----------------------------------------------------------------------------
module pscc_row_unit
	import pscc_pkg::*;
(
	input  row_req_t            req,
	input  logic [ROW_BITS-1:0] row_data,
	input  logic [EPOCH_W-1:0]  row_tag,
	input  logic [EPOCH_W-1:0]  epoch,
	output row_res_t            res
);

	localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(ROW_BITS - 1);

	logic [ROW_BITS-1:0] mask;
	logic [ROW_BITS-1:0] cur_row;

	// segment mask lo_bit..hi_bit
	always_comb begin
		mask = ({ROW_BITS{1'b1}} << req.lo_bit) & ({ROW_BITS{1'b1}} >> (TOP_BIT - req.hi_bit));
	end

	// rows written under an older epoch count as clear
	assign cur_row  = (row_tag == epoch) ? row_data : '0;
	assign res.hit  = |(cur_row & mask);
	assign res.data = cur_row | mask;

endmodule

// File: rtl/core/periodic_slot_conflict_checker_core.sv
// Sequence: accept, then a check of each occurrence (a periodic task stops at the
//   one past the horizon or map), a read and a check of each map row touched, then
//   finish; after a hit in its set a task goes from accept straight to finish.
// Throughput: one task at a time; the verdict is valid the cycle after finish.
// Reset: a clearing pass over all map rows (16384 by default) runs first.
// new_set is cheap via an epoch tag, except every 256th one, which repeats that pass.
// ----------------------------------------------------------------------------
// periodic_slot_conflict_checker_core
// Claims task cells on a row-organized occupancy bitmap and reports whether
// any cell was claimed twice within a set of tasks.
// ----------------------------------------------------------------------------
module periodic_slot_conflict_checker_core
	import pscc_pkg::*;
#(
	parameter int MAP_CELLS = MAP_CELLS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [TIME_W-1:0] horizon,
	// task input
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [TIME_W-1:0] start_time,
	input  logic [TIME_W-1:0] finish_time,
	input  logic [TIME_W-1:0] period,
	input  logic              new_set,
	input  logic              last_task,
	// verdict output
	output logic              out_valid,
	input  logic              out_ready,
	output logic              conflict
);

	localparam int ROWS  = (MAP_CELLS + ROW_BITS - 1) / ROW_BITS;
	localparam int ROW_W = $clog2(ROWS);
	localparam int MEM_W = ROW_BITS + EPOCH_W;
	localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
	localparam logic [CUR_W-1:0] LAST_CELL = CUR_W'(MAP_CELLS - 1);
	localparam logic [CUR_W-1:0] MAP_LIM   = CUR_W'(MAP_CELLS);

	state_t state_q, state_n;

	logic [EPOCH_W-1:0] epoch_q;
	logic               conflict_seen_q;
	logic [TIME_W-1:0]  horizon_q;
	logic               out_valid_q;
	logic               conflict_q;
	logic               pend_q;
	logic [ROW_W-1:0]   sweep_q;

	logic [CUR_W-1:0]   occ_lo_q;
	logic [CUR_W-1:0]   occ_hi_q;
	logic [CUR_W-1:0]   cur_q;
	logic [CUR_W-1:0]   hic_q;
	logic [TIME_W-1:0]  period_q;
	logic               last_q;
	logic               one_shot_q;

	logic               accept;
	logic               wrap_new;
	logic [CUR_W-1:0]   hi_clip;
	logic               past_horizon;
	logic               off_map;
	logic               occ_empty;
	logic [CUR_W-1:0]   row_end;
	logic               seg_last;
	logic [ROW_W-1:0]   row_addr;
	logic               sweep_done;

	logic               ram_we;
	logic [ROW_W-1:0]   ram_waddr;
	logic [MEM_W-1:0]   ram_wdata;
	logic [MEM_W-1:0]   ram_rdata;
	logic               out_load;
	logic               occ_step;

	row_req_t           row_req;
	row_res_t           row_res;

	// ports
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign conflict  = conflict_q;
	assign accept    = in_valid & in_ready;
	// epoch about to wrap: old tags could alias, so clear the map
	assign wrap_new  = new_set & (&epoch_q);

	// occurrence evaluation
	assign hi_clip      = (occ_hi_q > LAST_CELL) ? LAST_CELL : occ_hi_q;
	assign past_horizon = !one_shot_q && (occ_hi_q > CUR_W'(horizon_q));
	assign off_map      = occ_lo_q >= MAP_LIM;
	assign occ_empty    = occ_lo_q > hi_clip;

	// row segment of the cursor
	assign row_end         = {cur_q[CUR_W-1:BIT_W], {BIT_W{1'b1}}};
	assign seg_last        = hic_q <= row_end;
	assign row_addr        = cur_q[BIT_W +: ROW_W];
	assign row_req.lo_bit  = cur_q[BIT_W-1:0];
	assign row_req.hi_bit  = seg_last ? hic_q[BIT_W-1:0] : {BIT_W{1'b1}};
	assign sweep_done      = sweep_q == ROW_LAST;

	pscc_row_unit u_row (
		.req      (row_req),
		.row_data (ram_rdata[ROW_BITS-1:0]),
		.row_tag  (ram_rdata[MEM_W-1:ROW_BITS]),
		.epoch    (epoch_q),
		.res      (row_res)
	);

	pscc_ram #(
		.WIDTH (MEM_W),
		.DEPTH (ROWS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (row_addr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_SWEEP: begin
				if (sweep_done) begin
					state_n = pend_q ? ST_OCC : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (wrap_new) begin
						state_n = ST_SWEEP;
					end else if (conflict_seen_q && !new_set) begin
						state_n = ST_FIN;
					end else begin
						state_n = ST_OCC;
					end
				end
			end
			ST_OCC: begin
				if (past_horizon || off_map) begin
					state_n = ST_FIN;
				end else if (occ_empty) begin
					state_n = one_shot_q ? ST_FIN : ST_OCC;
				end else begin
					state_n = ST_READ;
				end
			end
			ST_READ: begin
				state_n = ST_CHECK;
			end
			ST_CHECK: begin
				if (row_res.hit) begin
					state_n = ST_FIN;
				end else if (seg_last) begin
					state_n = one_shot_q ? ST_FIN : ST_OCC;
				end else begin
					state_n = ST_READ;
				end
			end
			ST_FIN: begin
				if (!last_q || !out_valid_q || out_ready) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = row_addr;
		ram_wdata = {epoch_q, row_res.data};
		out_load  = 1'b0;
		occ_step  = 1'b0;
		case (state_q)
			ST_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_q;
				ram_wdata = {epoch_q, {ROW_BITS{1'b0}}};
			end
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_OCC: begin
				occ_step = !past_horizon && !off_map && occ_empty && !one_shot_q;
			end
			ST_CHECK: begin
				ram_we   = !row_res.hit;
				occ_step = !row_res.hit && seg_last && !one_shot_q;
			end
			ST_FIN: begin
				out_load = last_q && (!out_valid_q || out_ready);
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_SWEEP;
			epoch_q         <= '0;
			conflict_seen_q <= 1'b0;
			horizon_q       <= HORIZON_RESET;
			out_valid_q     <= 1'b0;
			pend_q          <= 1'b0;
			sweep_q         <= '0;
		end else begin
			state_q <= state_n;
			if (cfg_valid && cfg_ready) begin
				horizon_q <= horizon;
			end
			if (accept) begin
				pend_q <= wrap_new;
				if (new_set) begin
					epoch_q         <= epoch_q + 1'b1;
					conflict_seen_q <= 1'b0;
				end
			end
			if (state_q == ST_SWEEP) begin
				sweep_q <= sweep_done ? '0 : sweep_q + 1'b1;
				if (sweep_done) begin
					pend_q <= 1'b0;
				end
			end
			if (state_q == ST_CHECK && row_res.hit) begin
				conflict_seen_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// task and cursor registers
	always_ff @(posedge clk) begin
		if (accept) begin
			occ_lo_q   <= CUR_W'(start_time) + 1'b1;
			occ_hi_q   <= CUR_W'(finish_time);
			period_q   <= period;
			last_q     <= last_task;
			one_shot_q <= period == '0;
		end
		if (occ_step) begin
			occ_lo_q <= occ_lo_q + CUR_W'(period_q);
			occ_hi_q <= occ_hi_q + CUR_W'(period_q);
		end
		if (state_q == ST_OCC) begin
			cur_q <= occ_lo_q;
			hic_q <= hi_clip;
		end else if (state_q == ST_CHECK && !seg_last) begin
			cur_q <= row_end + 1'b1;
		end
		if (out_load) begin
			conflict_q <= conflict_seen_q;
		end
	end

`ifndef SYNTH
	// a row read never runs past the occurrence or the map
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (cur_q <= hic_q && hic_q <= LAST_CELL))
		else $error("cursor outside occurrence");

	// an overlap fixes the verdict and ends the walk
	a_hit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && row_res.hit) |=> (state_q == ST_FIN && conflict_seen_q))
		else $error("overlap did not end walk");

	// a verdict appears only when a last task finishes
	a_verdict_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN && last_q))
		else $error("verdict without last task");

	// a new set starts with a clear flag
	a_new_set_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && new_set) |=> !conflict_seen_q)
		else $error("flag not cleared on new set");
`endif

endmodule

// File: verif/periodic_slot_conflict_checker_core_tb.sv
// ----------------------------------------------------------------------------
// Periodic slot conflict checker core testbench
// Drives task reservations over valid/ready, including one-shot, periodic,
// empty, past-horizon and past-map ranges, with horizon writes between
// phases. A sparse copy of the occupancy map in the bench predicts each set
// verdict, and a monitor compares every verdict transaction against it.
// ----------------------------------------------------------------------------
module tb
	import pscc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     TIME_MAX      = (1 << TIME_W) - 1;
	localparam longint MAP_CELLS     = MAP_CELLS_DEF;
	// estimated block cycles allowed for one random task
	localparam longint CYCLE_BUDGET  = 1500;
	// margin after the last verdict before a horizon write
	localparam int     SETTLE_CYCLES = 16;
	localparam int     DRAIN_CYCLES  = 64;
	localparam int     CYCLE_LIMIT   = 5_000_000;

	typedef struct {
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] finish_time;
		logic [TIME_W-1:0] period;
		logic              new_set;
		logic              last_task;
	} sched_item_t;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              cfg_valid   = 1'b0;
	logic              cfg_ready;
	logic [TIME_W-1:0] horizon     = HORIZON_RESET;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [TIME_W-1:0] start_time  = '0;
	logic [TIME_W-1:0] finish_time = '0;
	logic [TIME_W-1:0] period      = '0;
	logic              new_set     = 1'b0;
	logic              last_task   = 1'b0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic              conflict;

	// bench copy of the block state
	bit                occ_cells [longint];
	bit                overlap_flag;
	logic [TIME_W-1:0] cur_horizon;
	bit                expected_verdicts [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int tasks_sent     = 0;
	int periodic_sent  = 0;
	int verdicts_seen  = 0;
	int overlaps_seen  = 0;
	int horizon_loads  = 0;

	periodic_slot_conflict_checker_core #(
		.MAP_CELLS(MAP_CELLS_DEF)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.horizon    (horizon),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_time (start_time),
		.finish_time(finish_time),
		.period     (period),
		.new_set    (new_set),
		.last_task  (last_task),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.conflict   (conflict)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Map prediction
	// ------------------------------------------------------------------------

	// one occurrence; returns 0 once its first cell lies past the map
	function automatic bit place_occurrence(longint lo, longint hi);
		if (lo >= MAP_CELLS)
			return 1'b0;
		if (hi >= MAP_CELLS)
			hi = MAP_CELLS - 1;
		for (longint c = lo; c <= hi; c++) begin
			if (occ_cells.exists(c)) begin
				overlap_flag = 1'b1;
				break;
			end
			occ_cells[c] = 1'b1;
		end
		return 1'b1;
	endfunction

	function automatic void apply_task_to_map(sched_item_t t);
		longint s, f, p, off;
		s = t.start_time;
		f = t.finish_time;
		p = t.period;
		if (t.new_set) begin
			occ_cells.delete();
			overlap_flag = 1'b0;
		end
		// once a set has overlapped the verdict is fixed and nothing is walked
		if (!overlap_flag) begin
			if (p == 0) begin
				void'(place_occurrence(s + 1, f));
			end else begin
				off = 0;
				while (f + off <= longint'(cur_horizon) && !overlap_flag) begin
					if (!place_occurrence(s + 1 + off, f + off))
						break;
					off += p;
				end
			end
		end
		if (t.last_task) begin
			expected_verdicts.push_back(overlap_flag);
			if (overlap_flag)
				overlaps_seen++;
		end
	endfunction

	// rough upper bound on block cycles, used to keep random tasks short
	function automatic longint work_estimate(sched_item_t t);
		longint lo, hi, p, rows, occ;
		lo = longint'(t.start_time) + 1;
		hi = t.finish_time;
		p = t.period;
		rows = (lo <= hi) ? (hi - lo) / 64 + 2 : 0;
		if (p == 0)
			occ = 1;
		else if (hi > longint'(cur_horizon))
			occ = 0;
		else begin
			occ = (longint'(cur_horizon) - hi) / p + 1;
			// a period shorter than the range overlaps on its second pass
			if (rows != 0 && p <= hi - lo && occ > 2)
				occ = 2;
		end
		return 4 + occ * (1 + 2 * rows);
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic sched_item_t make_task_item(int s, int f, int p, bit ns, bit lt);
		sched_item_t t;
		t.start_time  = s[TIME_W-1:0];
		t.finish_time = f[TIME_W-1:0];
		t.period      = p[TIME_W-1:0];
		t.new_set     = ns;
		t.last_task   = lt;
		return t;
	endfunction

	// random task placed in a window; redrawn while it would run too long
	function automatic sched_item_t draw_item(longint base, longint win, bit ns, bit lt);
		sched_item_t t;
		longint      s, f, span, p;
		int          pick;
		t.new_set = ns;
		t.last_task = lt;
		for (int tries = 0; tries < 24; tries++) begin
			if ($urandom_range(0, 19) == 0) begin
				// stray task: every field over its whole range
				s = $urandom_range(0, TIME_MAX);
				f = $urandom_range(0, TIME_MAX);
				p = $urandom_range(0, TIME_MAX);
			end else begin
				s = base + $urandom_range(0, int'(win));
				if (s > TIME_MAX)
					s = TIME_MAX;
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					f = s - $urandom_range(0, 3);
					if (f < 0)
						f = 0;
				end else if (pick <= 7) begin
					f = s + $urandom_range(1, 64);
				end else begin
					f = s + $urandom_range(65, int'(win));
				end
				if (f > TIME_MAX)
					f = TIME_MAX;
				span = (f > s) ? f - s : 0;
				pick = $urandom_range(0, 19);
				if (pick < 5)
					p = 0;
				else if (pick < 13)
					p = span + 1 + $urandom_range(0, int'(2 * span + 64));
				else if (pick < 16)
					p = $urandom_range(1, (span > 0) ? int'(span) : 1);
				else
					p = $urandom_range(0, TIME_MAX);
				if (p > TIME_MAX)
					p = TIME_MAX;
			end
			t.start_time  = s[TIME_W-1:0];
			t.finish_time = f[TIME_W-1:0];
			t.period      = p[TIME_W-1:0];
			if (work_estimate(t) <= CYCLE_BUDGET)
				return t;
		end
		// fall back to an empty one-shot task
		t.finish_time = t.start_time;
		t.period = '0;
		return t;
	endfunction

	// one task transaction, with an optional idle gap ahead of it
	task automatic push_task_item(sched_item_t t);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid    <= 1'b1;
		start_time  <= t.start_time;
		finish_time <= t.finish_time;
		period      <= t.period;
		new_set     <= t.new_set;
		last_task   <= t.last_task;
		do
			@(posedge clk);
		while (!in_ready);
		apply_task_to_map(t);
		tasks_sent++;
		if (t.period != '0)
			periodic_sent++;
	endtask

	// horizon write, only once every pending verdict has come back
	task automatic load_horizon(logic [TIME_W-1:0] hz);
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		horizon   <= hz;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_horizon = hz;
		horizon_loads++;
	endtask

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------------
	// Receiver side: random stall and verdict check
	// ------------------------------------------------------------------------

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin : verdict_check
		bit want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_verdicts.size() == 0) begin
				report_mismatch($sformatf("verdict conflict=%b with no set pending", conflict));
			end else begin
				want = expected_verdicts.pop_front();
				verdicts_seen++;
				if (conflict !== want)
					report_mismatch($sformatf("verdict %0d: conflict=%b, expected %b",
						verdicts_seen, conflict, want));
			end
		end
	end

	// run limit
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Timeout after %0d cycles, %0d verdicts outstanding",
			CYCLE_LIMIT, expected_verdicts.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// whole-map claim, empty range, first cell past the map, top cell
	task automatic test_one_shot_edges();
		push_task_item(make_task_item(0, TIME_MAX, 0, 1, 0));
		push_task_item(make_task_item(0, 0, 0, 0, 1));
		push_task_item(make_task_item(TIME_MAX, TIME_MAX, 0, 1, 0));
		push_task_item(make_task_item(TIME_MAX - 1, TIME_MAX, 0, 0, 1));
	endtask

	// overlap raises the flag, it stays set, clear and verdict in one task
	task automatic test_overlap_sticky();
		push_task_item(make_task_item(100, 200, 0, 1, 0));
		push_task_item(make_task_item(150, 160, 0, 0, 0));
		push_task_item(make_task_item(300, 310, 0, 0, 1));
		push_task_item(make_task_item(10, 20, 0, 1, 1));
	endtask

	// periodic behavior against the reset horizon
	task automatic test_periodic_reset_horizon();
		// one-shot ignores the horizon
		push_task_item(make_task_item(999995, 1000010, 0, 1, 0));
		push_task_item(make_task_item(1000005, 1000006, 0, 0, 1));
		// periodic finishing past the horizon claims nothing
		push_task_item(make_task_item(999000, 1000001, 7, 1, 0));
		push_task_item(make_task_item(999500, 999600, 0, 0, 1));
		// empty periodic range still steps through its occurrences
		push_task_item(make_task_item(50, 40, 1000, 1, 0));
		push_task_item(make_task_item(0, 5, 0, 0, 1));
		// period shorter than the range overlaps itself
		push_task_item(make_task_item(0, 100, 50, 1, 1));
		// many clean repeats, then a hit on a later occurrence
		push_task_item(make_task_item(0, 10, 100, 1, 0));
		push_task_item(make_task_item(995, 1005, 0, 0, 1));
	endtask

	// horizon at zero and at its maximum
	task automatic test_horizon_extremes();
		load_horizon('0);
		push_task_item(make_task_item(0, 0, 1, 1, 0));
		push_task_item(make_task_item(5, 9, 3, 0, 0));
		push_task_item(make_task_item(0, 9, 0, 0, 1));
		load_horizon(TIME_W'(TIME_MAX));
		push_task_item(make_task_item(TIME_MAX, TIME_MAX, 5, 1, 0));
		push_task_item(make_task_item(TIME_MAX - 5, TIME_MAX, TIME_MAX, 0, 0));
		push_task_item(make_task_item(0, 0, TIME_MAX, 0, 0));
		push_task_item(make_task_item(1048000, TIME_MAX, 0, 0, 1));
		push_task_item(make_task_item(524287, 524288, 524288, 1, 1));
	endtask

	// mostly well-formed sets of tasks sharing a window, some malformed
	task automatic run_random_phase(int n_items, logic [TIME_W-1:0] hz);
		int     sent, set_len;
		longint base, win;
		bit     ns, lt;
		load_horizon(hz);
		sent = 0;
		while (sent < n_items) begin
			set_len = $urandom_range(1, 8);
			win = ($urandom_range(0, 3) == 0) ? 4096 : 512;
			case ($urandom_range(0, 3))
				0, 1: base = (longint'(hz) > 2 * win) ?
					longint'(hz) - win - $urandom_range(0, int'(win)) : 0;
				2: base = $urandom_range(0, int'(hz));
				default: base = $urandom_range(0, TIME_MAX - int'(win));
			endcase
			for (int i = 0; i < set_len; i++) begin
				ns = (i == 0);
				lt = (i == set_len - 1);
				// malformed sets: stray clear or early verdict
				if ($urandom_range(0, 9) == 0)
					ns = ~ns;
				if (!lt && $urandom_range(0, 14) == 0)
					lt = 1'b1;
				push_task_item(draw_item(base, win, ns, lt));
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		overlap_flag = 1'b0;
		cur_horizon = HORIZON_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct  = 38;
		recv_stall_pct = 45;
		test_one_shot_edges();
		test_overlap_sticky();
		test_periodic_reset_horizon();
		test_horizon_extremes();
		run_random_phase(93, TIME_W'(4095));
		run_random_phase(93, TIME_W'($urandom_range(20000, 200000)));

		send_idle_pct  = 45;
		recv_stall_pct = 38;
		run_random_phase(93, TIME_W'(TIME_MAX));
		run_random_phase(93, TIME_W'($urandom_range(0, TIME_MAX)));

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random_phase(93, TIME_W'($urandom_range(0, 1023)));
		run_random_phase(93, HORIZON_RESET);

		// drain
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d tasks (%0d periodic) under %0d horizon writes",
			tasks_sent, periodic_sent, horizon_loads);
		$display("%0d set verdicts checked, %0d of them overlapping, %0d mismatches",
			verdicts_seen, overlaps_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
